// ===== src/rscs_pkg.sv =====
package rscs_pkg;

    // Event codes carried on the slave-side tuser.
    localparam logic [1:0] OP_SELECT  = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_BYTE    = 2'd2;

    // Command opcodes.
    localparam logic [7:0] CMD_STANDBY     = 8'h80;
    localparam logic [7:0] CMD_RECEIVE     = 8'h82;
    localparam logic [7:0] CMD_TRANSMIT    = 8'h83;
    localparam logic [7:0] CMD_READ_REG    = 8'h1D;
    localparam logic [7:0] CMD_WRITE_BUF   = 8'h0E;
    localparam logic [7:0] CMD_READ_FLAGS  = 8'h12;
    localparam logic [7:0] CMD_CLEAR_FLAGS = 8'h02;

    // Radio modes.
    localparam logic [2:0] MODE_STANDBY  = 3'd2;
    localparam logic [2:0] MODE_RECEIVE  = 3'd5;
    localparam logic [2:0] MODE_TRANSMIT = 3'd6;

    localparam logic [15:0] FLAG_TX_DONE = 16'h0001;

    localparam int          REG_ADDR_BITS = 12;
    localparam logic [15:0] SYNC_ADDR_HI  = 16'h0740;
    localparam logic [15:0] SYNC_ADDR_LO  = SYNC_ADDR_HI + 16'd1;
    localparam logic [15:0] SYNC_WORD_RST = 16'h3444;

    localparam int OUT_BITS  = 52;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef struct packed {
        logic        selected;
        logic [7:0]  byte_position;
        logic [7:0]  opcode;
        logic [7:0]  param_high;
        logic [7:0]  param_low;
        logic [2:0]  mode;
        logic [15:0] flags;
        logic [7:0]  length;
    } state_t;

    // Last member sits in the lowest bits.
    typedef struct packed {
        logic [7:0]  payload_data;
        logic [7:0]  payload_index;
        logic        payload_write;
        logic [7:0]  payload_length;
        logic [15:0] irq_flags;
        logic [2:0]  radio_mode;
        logic [7:0]  reply_byte;
    } result_t;

endpackage

// ===== src/radio_spi_command_slave.sv =====
// SPI command slave of a radio model, one byte event per transfer.
// Slave side: s_tuser carries the event (select, release, byte) and s_tdata
// the host byte. Each select, and each byte while selected, yields one
// master-side transfer with the reply byte for the next SPI transfer plus
// the radio mode, interrupt flags, payload length and a payload memory write
// (write strobe, address, data). Release events, bytes while deselected and
// the unused event code yield no transfer; a release only clears selection.
// An accepted event is held in the input register, decoded combinationally
// from it, and its result is registered in the output register, from which
// it is offered on the master side. One event per cycle is sustained while
// the receiver takes results; the single decode stage between the input and
// output registers sets that figure.
// When the receiver stalls, the output register holds its result and the
// input register holds one more event; s_tready falls once both are full.
// Reset clears the transaction state, sets the mode to standby, clears the
// flags and length and loads the sync word with 0x3444. cfg_wr_en writes
// the sync word; the user must write it only while no event is in flight (unenforced).
module radio_spi_command_slave
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    // reply_byte, radio_mode, irq_flags, payload_length, payload_write,
    // payload_index, payload_data, zero fill
    output logic [rscs_pkg::OUT_BYTES*8-1:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic              in_valid_reg;
    logic [1:0]        in_op_reg;
    logic [7:0]        in_byte_reg;
    logic              advance;
    rscs_pkg::state_t  state_reg;
    rscs_pkg::state_t  state_next;
    logic              has_result;
    rscs_pkg::result_t result_next;
    rscs_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic [15:0]       sync_word_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rscs_pkg::OUT_BYTES*8 - rscs_pkg::OUT_BITS){1'b0}}, out_reg};

    rscs_decode u_decode
    (
        .cur        (state_reg),
        .operation  (in_op_reg),
        .rx_byte    (in_byte_reg),
        .sync_word  (sync_word_reg),
        .nxt        (state_next),
        .has_result (has_result),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sync_word_reg <= rscs_pkg::SYNC_WORD_RST;
            state_reg     <= '{selected: 1'b0, byte_position: 8'd0, opcode: 8'd0,
                               param_high: 8'd0, param_low: 8'd0,
                               mode: rscs_pkg::MODE_STANDBY, flags: 16'd0,
                               length: 8'd0};
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sync_word_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= has_result;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance && has_result)
        begin
            out_reg <= result_next;
        end
    end

endmodule

// ===== src/rscs_decode.sv =====
module rscs_decode
(
    input  rscs_pkg::state_t  cur,
    input  logic [1:0]        operation,
    input  logic [7:0]        rx_byte,
    input  logic [15:0]       sync_word,
    output rscs_pkg::state_t  nxt,
    output logic              has_result,
    output rscs_pkg::result_t result
);

    logic [7:0]  pos;
    logic [7:0]  status;
    logic [16:0] addr_sum;
    logic [rscs_pkg::REG_ADDR_BITS-1:0] reg_addr;
    logic [7:0]  reg_data;

    assign pos = cur.byte_position + 8'd1;

    // Register address for read-register: base from the two parameter bytes,
    // advancing from the fourth byte on and wrapping to the address width.
    assign addr_sum = {1'b0, cur.param_high, cur.param_low} + {9'd0, pos} - 17'd4;
    assign reg_addr = addr_sum[rscs_pkg::REG_ADDR_BITS-1:0];

    always_comb
    begin
        if (reg_addr == rscs_pkg::SYNC_ADDR_HI[rscs_pkg::REG_ADDR_BITS-1:0])
        begin
            reg_data = sync_word[15:8];
        end
        else if (reg_addr == rscs_pkg::SYNC_ADDR_LO[rscs_pkg::REG_ADDR_BITS-1:0])
        begin
            reg_data = sync_word[7:0];
        end
        else
        begin
            reg_data = 8'd0;
        end
    end

    always_comb
    begin
        nxt        = cur;
        has_result = 1'b0;
        status     = 8'd0;
        result     = '0;

        case (operation)
            rscs_pkg::OP_SELECT:
            begin
                nxt.selected      = 1'b1;
                nxt.byte_position = 8'd0;
                has_result        = 1'b1;
            end
            rscs_pkg::OP_RELEASE:
            begin
                nxt.selected = 1'b0;
            end
            rscs_pkg::OP_BYTE:
            begin
                if (cur.selected)
                begin
                    has_result        = 1'b1;
                    nxt.byte_position = pos;
                    if (pos == 8'd1)
                    begin
                        nxt.opcode = rx_byte;
                    end
                    if (pos == 8'd2)
                    begin
                        nxt.param_high = rx_byte;
                    end
                    if (pos == 8'd3)
                    begin
                        nxt.param_low = rx_byte;
                    end

                    if (pos == 8'd1)
                    begin
                        case (rx_byte)
                            rscs_pkg::CMD_STANDBY:
                            begin
                                nxt.mode = rscs_pkg::MODE_STANDBY;
                            end
                            rscs_pkg::CMD_TRANSMIT:
                            begin
                                nxt.mode  = rscs_pkg::MODE_TRANSMIT;
                                nxt.flags = cur.flags | rscs_pkg::FLAG_TX_DONE;
                            end
                            rscs_pkg::CMD_RECEIVE:
                            begin
                                nxt.mode  = rscs_pkg::MODE_RECEIVE;
                                nxt.flags = cur.flags & ~rscs_pkg::FLAG_TX_DONE;
                            end
                            default:
                            begin
                            end
                        endcase
                    end

                    // The status byte reflects the mode after this byte.
                    status            = {1'b0, nxt.mode, 4'b0100};
                    result.reply_byte = status;

                    if (pos != 8'd1)
                    begin
                        case (cur.opcode)
                            rscs_pkg::CMD_READ_REG:
                            begin
                                if (pos >= 8'd4)
                                begin
                                    result.reply_byte = reg_data;
                                end
                            end
                            rscs_pkg::CMD_WRITE_BUF:
                            begin
                                if (pos == 8'd2)
                                begin
                                    nxt.length = 8'd0;
                                end
                                else if (pos > 8'd2)
                                begin
                                    result.payload_write = 1'b1;
                                    result.payload_index = cur.param_high + pos - 8'd3;
                                    result.payload_data  = rx_byte;
                                    nxt.length           = cur.param_high + pos - 8'd2;
                                end
                            end
                            rscs_pkg::CMD_READ_FLAGS:
                            begin
                                if (pos == 8'd2)
                                begin
                                    result.reply_byte = cur.flags[15:8];
                                end
                                else if (pos == 8'd3)
                                begin
                                    result.reply_byte = cur.flags[7:0];
                                end
                            end
                            rscs_pkg::CMD_CLEAR_FLAGS:
                            begin
                                if (pos == 8'd2)
                                begin
                                    nxt.flags = cur.flags & ~{rx_byte, 8'd0};
                                end
                                else if (pos == 8'd3)
                                begin
                                    nxt.flags = cur.flags & ~{cur.param_high, rx_byte};
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.radio_mode     = nxt.mode;
        result.irq_flags      = nxt.flags;
        result.payload_length = nxt.length;
    end

endmodule

// ===== src/rscs_checker.sv =====
module rscs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [rscs_pkg::OUT_BYTES*8-1:0] m_tdata
);

    // A stalled result must stay in place until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only the three defined radio modes can be reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:8] == rscs_pkg::MODE_STANDBY ||
                      m_tdata[10:8] == rscs_pkg::MODE_RECEIVE ||
                      m_tdata[10:8] == rscs_pkg::MODE_TRANSMIT))
        else $error("undefined radio mode reported");

    // Without a payload write the address and data fields are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[35] |-> m_tdata[51:36] == 16'd0)
        else $error("payload fields set without a write");

    // A payload write always extends the length to one past its address.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[35] |-> m_tdata[34:27] == m_tdata[43:36] + 8'd1)
        else $error("payload length does not follow the written address");

endmodule

bind radio_spi_command_slave rscs_checker u_rscs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
